>>> sv/dynamic_priority_scheduler_defines.svh
// ----------------------------------------------------------------------------
// Dynamic priority scheduler assertion macros
// Concurrent check macros used by the scheduler datapath. They compile to nothing
// when SYNTHESIS is defined. The enclosing module supplies clk and rst_n.
// ----------------------------------------------------------------------------
`ifndef DYNAMIC_PRIORITY_SCHEDULER_DEFINES_SVH
`define DYNAMIC_PRIORITY_SCHEDULER_DEFINES_SVH

`ifndef SYNTHESIS
// Checked only while out of reset.
`define DPS_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("dps check failed");
// Checked at every edge, reset included.
`define DPS_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("dps check failed");
`else
`define DPS_ASSERT(lbl, prop)
`define DPS_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

>>> sv/dps_pkg.sv
// ----------------------------------------------------------------------------
// Dynamic priority scheduler package
// Widths, entry layout, controller states and the command and status groups
// passed between the controller and the datapath.
// ----------------------------------------------------------------------------
package dps_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int OCC_W       = $clog2(QUEUE_DEPTH + 1);
    // Index arithmetic reaches idx + 2, so compares get one spare bit.
    localparam int CMP_W       = OCC_W + 1;
    localparam int ID_W        = 8;
    localparam int PRIO_W      = 16;
    localparam int TIME_W      = 16;
    localparam int COUNT_W     = 5;
    localparam int IN_DATA_W   = 56;
    localparam int OUT_DATA_W  = 48;

    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic signed [PRIO_W-1:0] PRIO_MIN = {1'b1, {(PRIO_W-1){1'b0}}};

    typedef struct packed {
        logic signed [PRIO_W-1:0] prio;
        logic [ID_W-1:0]          id;
        logic [TIME_W-1:0]        need;
        logic [TIME_W-1:0]        used;
        logic [TIME_W-1:0]        arrival;
    } entry_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_REM,
        ST_RUN,
        ST_INS_INIT,
        ST_INS_RD,
        ST_INS_CMP,
        ST_PUT,
        ST_RESP
    } dps_state_t;

    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_ZERO,
        IDX_OCC,
        IDX_INC,
        IDX_DEC
    } idx_op_t;

    typedef enum logic [2:0] {
        RD_ZERO,
        RD_P1,
        RD_P2,
        RD_M1,
        RD_M2
    } addr_sel_t;

    typedef struct packed {
        logic      load_new;
        logic      capture;
        logic      run;
        logic      tick_inc;
        idx_op_t   idx_op;
        logic      rd_en;
        addr_sel_t rd_sel;
        logic      wr_en;
        logic      wr_hold;
        logic      occ_inc;
        logic      occ_dec;
        logic      set_acc;
        logic      clr_res;
        logic      out_load;
    } dps_cmd_t;

    typedef struct packed {
        logic occ_zero;
        logic occ_full;
        logic scan_hit;
        logic scan_last;
        logic rem_last;
        logic run_done;
        logic idx_zero;
        logic idx_one;
        logic ins_lower;
        logic out_free;
    } dps_sts_t;

endpackage

>>> sv/dps_ctrl.sv
// ----------------------------------------------------------------------------
// Dynamic priority scheduler controller
// Sequences the queue scan, removal shift, sorted reinsertion and response
// for one item at a time.
// ----------------------------------------------------------------------------
module dps_ctrl
    import dps_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  logic     in_op,
    output logic     in_ready,
    input  dps_sts_t sts,
    output dps_cmd_t cmd
);

    dps_state_t state_reg;
    dps_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_op == OP_TICK)
                    begin
                        state_next = sts.occ_zero ? ST_RESP : ST_SCAN;
                    end
                    else
                    begin
                        state_next = sts.occ_full ? ST_RESP : ST_INS_INIT;
                    end
                end
            end
            ST_SCAN:
            begin
                if (sts.scan_hit)
                begin
                    state_next = sts.scan_last ? ST_RUN : ST_REM;
                end
                else if (sts.scan_last)
                begin
                    state_next = ST_RESP;
                end
            end
            ST_REM:
            begin
                if (sts.rem_last)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                state_next = sts.run_done ? ST_RESP : ST_INS_INIT;
            end
            ST_INS_INIT:
            begin
                state_next = ST_INS_RD;
            end
            ST_INS_RD:
            begin
                state_next = sts.idx_zero ? ST_PUT : ST_INS_CMP;
            end
            ST_INS_CMP:
            begin
                if (!sts.ins_lower || sts.idx_one)
                begin
                    state_next = ST_PUT;
                end
            end
            ST_PUT:
            begin
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd        = '0;
        cmd.idx_op = IDX_HOLD;
        cmd.rd_sel = RD_ZERO;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.clr_res = 1'b1;
                    if (in_op == OP_TICK)
                    begin
                        cmd.tick_inc = 1'b1;
                        cmd.idx_op   = IDX_ZERO;
                        cmd.rd_en    = !sts.occ_zero;
                        cmd.rd_sel   = RD_ZERO;
                    end
                    else if (!sts.occ_full)
                    begin
                        cmd.load_new = 1'b1;
                        cmd.set_acc  = 1'b1;
                    end
                end
            end
            ST_SCAN:
            begin
                if (sts.scan_hit)
                begin
                    cmd.capture = 1'b1;
                    cmd.rd_en   = !sts.scan_last;
                    cmd.rd_sel  = RD_P1;
                    cmd.occ_dec = sts.scan_last;
                end
                else if (!sts.scan_last)
                begin
                    cmd.idx_op = IDX_INC;
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_P1;
                end
            end
            ST_REM:
            begin
                // Close the gap left by the picked entry, one slot a cycle.
                cmd.wr_en = 1'b1;
                if (!sts.rem_last)
                begin
                    cmd.idx_op = IDX_INC;
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_P2;
                end
                else
                begin
                    cmd.occ_dec = 1'b1;
                end
            end
            ST_RUN:
            begin
                cmd.run = 1'b1;
            end
            ST_INS_INIT:
            begin
                cmd.idx_op = IDX_OCC;
            end
            ST_INS_RD:
            begin
                cmd.rd_en  = !sts.idx_zero;
                cmd.rd_sel = RD_M1;
            end
            ST_INS_CMP:
            begin
                // Entries of lower priority move one slot toward the tail.
                if (sts.ins_lower)
                begin
                    cmd.wr_en  = 1'b1;
                    cmd.idx_op = IDX_DEC;
                    cmd.rd_en  = !sts.idx_one;
                    cmd.rd_sel = RD_M2;
                end
            end
            ST_PUT:
            begin
                cmd.wr_en   = 1'b1;
                cmd.wr_hold = 1'b1;
                cmd.occ_inc = 1'b1;
            end
            ST_RESP:
            begin
                cmd.out_load = sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

>>> sv/dps_dp.sv
// ----------------------------------------------------------------------------
// Dynamic priority scheduler datapath
// Queue memory with one write and one registered read port, index and
// occupancy counters, tick counter, working entry and output register.
// ----------------------------------------------------------------------------
`include "dynamic_priority_scheduler_defines.svh"

module dps_dp
    import dps_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  dps_cmd_t                 cmd,
    output dps_sts_t                 sts,
    input  logic [ID_W-1:0]          proc_id,
    input  logic signed [PRIO_W-1:0] priority_req,
    input  logic [TIME_W-1:0]        need_time,
    input  logic [TIME_W-1:0]        arrival_time,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [OUT_DATA_W-1:0]    out_data
);

    entry_t                mem [QUEUE_DEPTH];
    entry_t                rdata_reg;
    entry_t                hold_reg;
    entry_t                wr_data;
    logic [IDX_W-1:0]      idx_reg;
    logic [IDX_W-1:0]      idx_next;
    logic [IDX_W-1:0]      rd_addr;
    logic [IDX_W-1:0]      wr_addr;
    logic [OCC_W-1:0]      occ_reg;
    logic [TIME_W-1:0]     tick_reg;
    logic                  res_acc_reg;
    logic                  res_run_reg;
    logic                  res_fin_reg;
    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic [OUT_DATA_W-1:0] out_data_next;
    logic [CMP_W-1:0]      idx_w;
    logic [CMP_W-1:0]      occ_w;
    logic [TIME_W-1:0]     used_inc;
    logic [TIME_W-1:0]     eff_need;
    logic                  fin;
    logic signed [PRIO_W-1:0] prio_dec;
    logic [ID_W-1:0]       res_id;
    logic [PRIO_W-1:0]     res_prio;

    assign idx_w   = CMP_W'(idx_reg);
    assign occ_w   = CMP_W'(occ_reg);
    assign wr_addr = idx_reg;
    assign wr_data = cmd.wr_hold ? hold_reg : rdata_reg;

    always_comb
    begin
        case (cmd.rd_sel)
            RD_ZERO: rd_addr = '0;
            RD_P1:   rd_addr = idx_reg + IDX_W'(1);
            RD_P2:   rd_addr = idx_reg + IDX_W'(2);
            RD_M1:   rd_addr = idx_reg - IDX_W'(1);
            RD_M2:   rd_addr = idx_reg - IDX_W'(2);
            default: rd_addr = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        case (cmd.idx_op)
            IDX_ZERO: idx_next = '0;
            IDX_OCC:  idx_next = IDX_W'(occ_reg);
            IDX_INC:  idx_next = idx_reg + IDX_W'(1);
            IDX_DEC:  idx_next = idx_reg - IDX_W'(1);
            default:  idx_next = idx_reg;
        endcase
    end

    // A need of zero counts as one; run time saturates at all ones.
    assign eff_need = (hold_reg.need == '0) ? TIME_W'(1) : hold_reg.need;
    assign used_inc = (hold_reg.used == '1) ? hold_reg.used
                                            : hold_reg.used + TIME_W'(1);
    assign fin      = (used_inc >= eff_need);
    assign prio_dec = (hold_reg.prio == PRIO_MIN) ? PRIO_MIN
                                                  : hold_reg.prio - PRIO_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            occ_reg       <= '0;
            tick_reg      <= '1;
            res_acc_reg   <= 1'b0;
            res_run_reg   <= 1'b0;
            res_fin_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg <= idx_next;
            if (cmd.occ_inc)
            begin
                occ_reg <= occ_reg + OCC_W'(1);
            end
            else if (cmd.occ_dec)
            begin
                occ_reg <= occ_reg - OCC_W'(1);
            end
            if (cmd.tick_inc)
            begin
                tick_reg <= tick_reg + TIME_W'(1);
            end
            if (cmd.clr_res)
            begin
                // An add that will be stored is marked accepted as it is taken.
                res_acc_reg <= cmd.set_acc;
                res_run_reg <= 1'b0;
                res_fin_reg <= 1'b0;
            end
            else if (cmd.run)
            begin
                res_acc_reg <= 1'b1;
                res_run_reg <= 1'b1;
                res_fin_reg <= fin;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_new)
        begin
            hold_reg.prio    <= priority_req;
            hold_reg.id      <= proc_id;
            hold_reg.need    <= need_time;
            hold_reg.used    <= '0;
            hold_reg.arrival <= arrival_time;
        end
        else if (cmd.capture)
        begin
            hold_reg <= rdata_reg;
        end
        else if (cmd.run)
        begin
            // A finishing process reports the priority it ran with.
            hold_reg.used <= used_inc;
            if (!fin)
            begin
                hold_reg.prio <= prio_dec;
            end
        end
        if (cmd.out_load)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign res_id   = res_run_reg ? hold_reg.id : '0;
    assign res_prio = res_run_reg ? hold_reg.prio : '0;
    assign out_data_next = {1'b0, COUNT_W'(occ_reg), tick_reg, res_prio,
                            res_fin_reg, res_id, res_acc_reg};

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign sts.occ_zero  = (occ_reg == '0);
    assign sts.occ_full  = (occ_w >= CMP_W'(QUEUE_DEPTH));
    assign sts.scan_hit  = (rdata_reg.arrival <= tick_reg);
    assign sts.scan_last = (idx_w + CMP_W'(1) >= occ_w);
    assign sts.rem_last  = (idx_w + CMP_W'(2) >= occ_w);
    assign sts.run_done  = fin;
    assign sts.idx_zero  = (idx_reg == '0);
    assign sts.idx_one   = (idx_reg == IDX_W'(1));
    assign sts.ins_lower = ($signed(rdata_reg.prio) < $signed(hold_reg.prio));
    assign sts.out_free  = !out_valid_reg || out_ready;

    `DPS_ASSERT_ALWAYS(a_occ_bound, occ_reg <= OCC_W'(QUEUE_DEPTH))
    `DPS_ASSERT(a_port_apart, (cmd.wr_en && cmd.rd_en) |-> (wr_addr != rd_addr))
    `DPS_ASSERT(a_tick_steady, !cmd.tick_inc |=> $stable(tick_reg))
    `DPS_ASSERT(a_occ_steady, (!cmd.occ_inc && !cmd.occ_dec) |=> $stable(occ_reg))

endmodule

>>> sv/dynamic_priority_scheduler.sv
// One item is in work at a time: a new add or tick is taken only in the cycle after the
// response of the last one loads, and output back-pressure delays that load.
// A full queue refuses an add and an empty queue ends a tick without a scan;
// either goes straight to its response.
// Reset clears occupancy and sets the tick counter to all ones; queue contents are kept.
// ----------------------------------------------------------------------------
// Dynamic priority scheduler
// Ready queue ordered by descending priority; a process run by a tick that does not finish drops one priority step.
// ----------------------------------------------------------------------------
module dynamic_priority_scheduler
    import dps_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // proc_id, priority_req, need_time, arrival_time
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // op
    input  logic                  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // accepted, ran_id, finished, new_priority, time_now, queue_count, zero pad
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    dps_cmd_t cmd;
    dps_sts_t sts;

    dps_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_op    (s_axis_tuser),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    dps_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .proc_id      (s_axis_tdata[7:0]),
        .priority_req ($signed(s_axis_tdata[23:8])),
        .need_time    (s_axis_tdata[39:24]),
        .arrival_time (s_axis_tdata[55:40]),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_data     (m_axis_tdata)
    );

endmodule
